// ===== src/sdz_pkg.sv =====
// ----------------------------------------------------------------------------
// sdz_pkg
// shared constants for the stick dead zone and axis snap block
// ----------------------------------------------------------------------------
package sdz_pkg;

  localparam int unsigned RawW   = 11;
  localparam int unsigned OutW   = 16;
  localparam int unsigned QW     = 15;
  localparam int unsigned NumCh  = 5;
  // quotient bits kept by the divider: 11-bit magnitude times 2^14 over span
  localparam int unsigned QuotW  = 25;
  localparam int unsigned DivW   = 16;
  localparam int unsigned DivStages = 5;
  localparam int unsigned DivBitsPerStage = QuotW / DivStages;

  // register map, word addresses
  localparam logic [2:0] RegCenter   = 3'd0;
  localparam logic [2:0] RegSpan     = 3'd1;
  localparam logic [2:0] RegDeadZone = 3'd2;
  localparam logic [2:0] RegMainMin  = 3'd3;
  localparam logic [2:0] RegCrossAbs = 3'd4;
  localparam logic [2:0] RegCrossRat = 3'd5;

  localparam logic [RawW-1:0] CenterRst   = 11'd1024;
  localparam logic [RawW-1:0] SpanRst     = 11'd660;
  localparam logic [QW-1:0]   DeadZoneRst = 15'd492;
  localparam logic [QW-1:0]   MainMinRst  = 15'd2458;
  localparam logic [QW-1:0]   CrossAbsRst = 15'd1311;
  localparam logic [QW-1:0]   CrossRatRst = 15'd5734;

  typedef struct packed {
    logic [RawW-1:0] center;
    logic [RawW-1:0] span;
    logic [QW-1:0]   dz_mag;
  } norm_cfg_t;

endpackage

// ===== src/sdz_norm.sv =====
// ----------------------------------------------------------------------------
// sdz_norm
// one channel: center, restoring division by span over five stages,
// saturation and dead zone; one item per cycle
// ----------------------------------------------------------------------------
module sdz_norm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [sdz_pkg::RawW-1:0]        raw_i,
  input  sdz_pkg::norm_cfg_t              cfg_i,
  output logic                            valid_o,
  output logic signed [sdz_pkg::OutW-1:0] value_o
);

  localparam int unsigned S  = sdz_pkg::DivStages;
  localparam int unsigned B  = sdz_pkg::DivBitsPerStage;
  localparam int unsigned QWd = sdz_pkg::QuotW;
  localparam int unsigned RW = sdz_pkg::DivW;
  localparam int unsigned OutW_l = sdz_pkg::OutW;

  // stage 0: center difference
  logic              v0_q;
  logic [10:0]       mag0_q;
  logic              neg0_q, zero0_q;
  logic signed [11:0] diff;
  assign diff = $signed({1'b0, raw_i}) - $signed({1'b0, cfg_i.center});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg0_q  <= diff[11];
    zero0_q <= (diff == 12'sd0);
    mag0_q  <= diff[11] ? 11'(-diff) : diff[10:0];
  end

  // divider stages: dividend is mag << 14, quotient built MSB first
  logic [S:0]            dv_q;
  logic [RW-1:0]         rem_q [S+1];
  logic [QWd-1:0]        num_q [S+1];
  logic [QWd-1:0]        quo_q [S+1];
  logic [S:0]            neg_q, zero_q;

  always_comb begin
    dv_q[0]   = v0_q;
    rem_q[0]  = '0;
    num_q[0]  = {mag0_q, 14'd0};
    quo_q[0]  = '0;
    neg_q[0]  = neg0_q;
    zero_q[0] = zero0_q;
  end

  for (genvar s = 0; s < S; s++) begin : g_div
    logic [RW-1:0]  rem_d;
    logic [QWd-1:0] num_d, quo_d;
    logic [RW:0]    trial;
    always_comb begin
      rem_d = rem_q[s];
      num_d = num_q[s];
      quo_d = quo_q[s];
      for (int b = 0; b < B; b++) begin
        trial = {rem_d, num_d[QWd-1]} - {6'd0, cfg_i.span};
        num_d = {num_d[QWd-2:0], 1'b0};
        if (!trial[RW]) begin
          rem_d = trial[RW-1:0];
          quo_d = {quo_d[QWd-2:0], 1'b1};
        end else begin
          rem_d = {rem_d[RW-2:0], num_q[s][QWd-1-b]};
          quo_d = {quo_d[QWd-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else begin
        dv_q[s+1] <= dv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= rem_d;
      num_q[s+1]  <= num_d;
      quo_q[s+1]  <= quo_d;
      neg_q[s+1]  <= neg_q[s];
      zero_q[s+1] <= zero_q[s];
    end
  end

  // final stage: zero difference, span zero, saturation, sign, dead zone
  logic signed [OutW_l-1:0] sat;
  logic [QWd-1:0] q;
  logic signed [16:0] dz;
  assign q  = quo_q[S];
  assign dz = $signed({2'b0, cfg_i.dz_mag});

  always_comb begin
    priority if (zero_q[S]) begin
      sat = '0;
    end else if (cfg_i.span == '0) begin
      sat = neg_q[S] ? 16'sh8000 : 16'sh7fff;
    end else if (!neg_q[S]) begin
      sat = (q > 25'd32767) ? 16'sh7fff : $signed(q[15:0]);
    end else begin
      sat = (q > 25'd32768) ? 16'sh8000 : $signed(16'(-q[15:0]));
    end
    if ($signed({sat[15], sat}) > -dz && $signed({sat[15], sat}) < dz) begin
      sat = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= dv_q[S];
    end
  end

  always_ff @(posedge clk_i) begin
    value_o <= sat;
  end

endmodule

// ===== src/stick_dead_zone_axis_snap.sv =====
// ----------------------------------------------------------------------------
// stick_dead_zone_axis_snap
// five-channel stick normalizer with dead zone and left stick axis snap
// ----------------------------------------------------------------------------
// usage:
//   pulse start with five raw 11-bit channels; busy is tied low, so a
//   transaction may be started in every cycle.
//   results appear on the five Q2.14 ports with done_o high for one cycle,
//   in start order; throughput one per cycle.
//   each channel passes a centering stage, the five-stage restoring divider
//   (five quotient bits per stage) and a saturation stage, then the snap stages.
//   the receiver cannot stall; each result must be taken when done_o is high.
//   configuration over the APB port: center, span, dead zone, main axis
//   minimum, cross absolute limit, cross ratio at byte addresses 0..20.
//   write registers only while no transaction is in flight.
//   reset clears the pipeline valid bits and loads default register values.
// ----------------------------------------------------------------------------
module stick_dead_zone_axis_snap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [sdz_pkg::RawW-1:0]        right_x_raw_i,
  input  logic [sdz_pkg::RawW-1:0]        right_y_raw_i,
  input  logic [sdz_pkg::RawW-1:0]        left_x_raw_i,
  input  logic [sdz_pkg::RawW-1:0]        left_y_raw_i,
  input  logic [sdz_pkg::RawW-1:0]        yaw_raw_i,
  output logic                            done_o,
  output logic signed [sdz_pkg::OutW-1:0] right_x_o,
  output logic signed [sdz_pkg::OutW-1:0] right_y_o,
  output logic signed [sdz_pkg::OutW-1:0] left_x_o,
  output logic signed [sdz_pkg::OutW-1:0] left_y_o,
  output logic signed [sdz_pkg::OutW-1:0] yaw_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [4:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [10:0] center_q, span_q;
  logic [14:0] dz_q, main_min_q, cross_abs_q, cross_rat_q;
  logic        wr;
  logic [2:0]  widx;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign widx   = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q    <= sdz_pkg::CenterRst;
      span_q      <= sdz_pkg::SpanRst;
      dz_q        <= sdz_pkg::DeadZoneRst;
      main_min_q  <= sdz_pkg::MainMinRst;
      cross_abs_q <= sdz_pkg::CrossAbsRst;
      cross_rat_q <= sdz_pkg::CrossRatRst;
    end else if (wr) begin
      unique case (widx)
        sdz_pkg::RegCenter:   center_q    <= pwdata[10:0];
        sdz_pkg::RegSpan:     span_q      <= pwdata[10:0];
        sdz_pkg::RegDeadZone: dz_q        <= pwdata[14:0];
        sdz_pkg::RegMainMin:  main_min_q  <= pwdata[14:0];
        sdz_pkg::RegCrossAbs: cross_abs_q <= pwdata[14:0];
        sdz_pkg::RegCrossRat: cross_rat_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (widx)
      sdz_pkg::RegCenter:   prdata = {21'd0, center_q};
      sdz_pkg::RegSpan:     prdata = {21'd0, span_q};
      sdz_pkg::RegDeadZone: prdata = {17'd0, dz_q};
      sdz_pkg::RegMainMin:  prdata = {17'd0, main_min_q};
      sdz_pkg::RegCrossAbs: prdata = {17'd0, cross_abs_q};
      sdz_pkg::RegCrossRat: prdata = {17'd0, cross_rat_q};
      default:              prdata = '0;
    endcase
  end

  sdz_pkg::norm_cfg_t ncfg;
  assign ncfg = '{center: center_q, span: span_q, dz_mag: dz_q};

  logic [10:0]        raw [5];
  logic [4:0]         nv;
  logic signed [15:0] nval [5];
  assign raw[0] = right_x_raw_i;
  assign raw[1] = right_y_raw_i;
  assign raw[2] = left_x_raw_i;
  assign raw[3] = left_y_raw_i;
  assign raw[4] = yaw_raw_i;

  for (genvar c = 0; c < 5; c++) begin : g_ch
    sdz_norm u_norm (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (start),
      .raw_i   (raw[c]),
      .cfg_i   (ncfg),
      .valid_o (nv[c]),
      .value_o (nval[c])
    );
  end

  // snap stage 1: magnitudes and products
  logic        sv_q;
  logic signed [15:0] s_val_q [5];
  logic [15:0] ax_q, ay_q;
  logic [29:0] axs_q, ays_q, axr_q, ayr_q;
  logic [15:0] ax, ay;
  assign ax = nval[2][15] ? 16'(-nval[2]) : nval[2];
  assign ay = nval[3][15] ? 16'(-nval[3]) : nval[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= nv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    s_val_q <= nval;
    ax_q    <= ax;
    ay_q    <= ay;
    axs_q   <= {ax, 14'd0};
    ays_q   <= {ay, 14'd0};
    axr_q   <= {14'd0, ax} * {15'd0, cross_rat_q};
    ayr_q   <= {14'd0, ay} * {15'd0, cross_rat_q};
  end

  // snap stage 2: compares and output register
  logic zero_x, zero_y;
  assign zero_x = (ay_q > {1'b0, main_min_q}) && (ax_q < {1'b0, cross_abs_q})
                  && (axs_q < ayr_q);
  assign zero_y = (ax_q > {1'b0, main_min_q}) && (ay_q < {1'b0, cross_abs_q})
                  && (ays_q < axr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= sv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    right_x_o <= s_val_q[0];
    right_y_o <= s_val_q[1];
    left_x_o  <= zero_x ? '0 : s_val_q[2];
    left_y_o  <= zero_y ? '0 : s_val_q[3];
    yaw_o     <= s_val_q[4];
  end

endmodule

// ===== src/sdz_checker.sv =====
// ----------------------------------------------------------------------------
// sdz_checker
// port-level checks for the stick dead zone and axis snap block
// ----------------------------------------------------------------------------
module sdz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [15:0] left_x_o,
  input logic [15:0] left_y_o,
  input logic        pready
);

  // every transaction yields a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##9 done_o) else $error("missing result");

  // no result without a matching start
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 9)) else $error("spurious result");

  // input and config port never stall
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && pready) else $error("block stalled");

  // left stick outputs carry defined values with each result
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown({left_x_o, left_y_o})) else $error("unknown result");

endmodule

bind stick_dead_zone_axis_snap sdz_checker u_sdz_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .left_x_o (left_x_o),
  .left_y_o (left_y_o),
  .pready   (pready)
);

// ===== bench/stick_dead_zone_axis_snap_tb.sv =====
// ----------------------------------------------------------------------------
// stick_dead_zone_axis_snap_tb
// self-checking bench: directed and random frames through the normalizer, predicted
// outputs compared in order, over several register settings
// ----------------------------------------------------------------------------
module stick_dead_zone_axis_snap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sdz_pkg::RawW-1:0] rx, ry, lx, ly, yw;
  } frame_t;

  typedef struct packed {
    logic signed [sdz_pkg::OutW-1:0] rx, ry, lx, ly, yw;
  } stick_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [sdz_pkg::RawW-1:0] right_x_raw_i = '0, right_y_raw_i = '0, left_x_raw_i = '0;
  logic [sdz_pkg::RawW-1:0] left_y_raw_i = '0, yaw_raw_i = '0;
  logic done_o;
  logic signed [sdz_pkg::OutW-1:0] right_x_o, right_y_o, left_x_o, left_y_o, yaw_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stick_dead_zone_axis_snap dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the registers
  int unsigned m_center = sdz_pkg::CenterRst, m_span = sdz_pkg::SpanRst;
  int unsigned m_dz = sdz_pkg::DeadZoneRst, m_main = sdz_pkg::MainMinRst;
  int unsigned m_cabs = sdz_pkg::CrossAbsRst, m_crat = sdz_pkg::CrossRatRst;

  frame_t     frame_q[$];
  stick_out_t expected_q[$];
  int errors = 0;
  int frames_sent = 0;
  int results_seen = 0;

  function automatic int normalize_ch(logic [sdz_pkg::RawW-1:0] raw);
    int d, q;
    d = int'(raw) - int'(m_center);
    if (d == 0) return 0;
    if (m_span == 0) return d > 0 ? 32767 : -32768;
    q = ((d < 0 ? -d : d) * 16384) / int'(m_span);
    if (d > 0) return q > 32767 ? 32767 : q;
    return q > 32768 ? -32768 : -q;
  endfunction

  function automatic int dead_ch(int v);
    if (v > -int'(m_dz) && v < int'(m_dz)) return 0;
    return v;
  endfunction

  function automatic bit cross_snaps(longint main_mag, longint cross_mag);
    return main_mag > m_main && cross_mag < m_cabs &&
           cross_mag * 16384 < main_mag * m_crat;
  endfunction

  function automatic stick_out_t condition_frame(frame_t f);
    stick_out_t o;
    int lx, ly;
    longint ax, ay;
    bit zx, zy;
    lx = dead_ch(normalize_ch(f.lx));
    ly = dead_ch(normalize_ch(f.ly));
    ax = lx < 0 ? -lx : lx;
    ay = ly < 0 ? -ly : ly;
    zx = cross_snaps(ay, ax);
    zy = cross_snaps(ax, ay);
    o.rx = 16'(dead_ch(normalize_ch(f.rx)));
    o.ry = 16'(dead_ch(normalize_ch(f.ry)));
    o.lx = zx ? '0 : 16'(lx);
    o.ly = zy ? '0 : 16'(ly);
    o.yw = 16'(dead_ch(normalize_ch(f.yw)));
    return o;
  endfunction

  // driver: one frame per transaction, random gaps
  int gap = 0;
  always @(posedge clk_i) begin
    if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (rst_ni && frame_q.size() > 0 && !(start && busy)) begin
      frame_t f;
      f = frame_q.pop_front();
      right_x_raw_i <= f.rx; right_y_raw_i <= f.ry; left_x_raw_i <= f.lx;
      left_y_raw_i <= f.ly; yaw_raw_i <= f.yw;
      start <= 1'b1;
      expected_q.push_back(condition_frame(f));
      frames_sent <= frames_sent + 1;
      case ($urandom_range(0, 9))
        0, 1, 2: gap <= $urandom_range(1, 3);
        3:       gap <= $urandom_range(10, 40);
        default: gap <= 0;
      endcase
    end else if (!(start && busy)) begin
      start <= 1'b0;
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: got %h %h %h %h %h", $time,
                 right_x_o, right_y_o, left_x_o, left_y_o, yaw_o);
        errors++;
      end else begin
        stick_out_t e;
        e = expected_q.pop_front();
        results_seen++;
        if ({right_x_o, right_y_o, left_x_o, left_y_o, yaw_o} !== e) begin
          $display("%0t mismatch: expected rx=%0d ry=%0d lx=%0d ly=%0d yw=%0d",
                   $time, e.rx, e.ry, e.lx, e.ly, e.yw);
          $display("%0t           actual   rx=%0d ry=%0d lx=%0d ly=%0d yw=%0d",
                   $time, right_x_o, right_y_o, left_x_o, left_y_o, yaw_o);
          errors++;
        end
      end
    end
  end

  // apb write, only while idle
  task automatic reg_write(logic [2:0] idx, int unsigned val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      sdz_pkg::RegCenter:   m_center = val & 32'h7FF;
      sdz_pkg::RegSpan:     m_span   = val & 32'h7FF;
      sdz_pkg::RegDeadZone: m_dz     = val & 32'h7FFF;
      sdz_pkg::RegMainMin:  m_main   = val & 32'h7FFF;
      sdz_pkg::RegCrossAbs: m_cabs   = val & 32'h7FFF;
      sdz_pkg::RegCrossRat: m_crat   = val & 32'h7FFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (frame_q.size() > 0 || expected_q.size() > 0 || start) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [sdz_pkg::RawW-1:0] rand_raw();
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return 11'h7FF;
      2: return 11'(int'(m_center) + $urandom_range(0, 6) - 3);
      3: return 11'(int'(m_center) + $urandom_range(0, 60) - 30);
      default: return 11'($urandom);
    endcase
  endfunction

  // left stick mostly along one axis so snapping gets exercised
  task automatic queue_random(int n);
    frame_t f;
    repeat (n) begin
      f.rx = rand_raw(); f.ry = rand_raw(); f.yw = rand_raw();
      f.lx = rand_raw(); f.ly = rand_raw();
      if ($urandom_range(0, 2) == 0) f.ly = 11'(int'(m_center) + $urandom_range(0, 80) - 40);
      else if ($urandom_range(0, 2) == 0)
        f.lx = 11'(int'(m_center) + $urandom_range(0, 80) - 40);
      frame_q.push_back(f);
    end
  endtask

  task automatic queue_frame(int a, int b, int c, int d, int e);
    frame_q.push_back({11'(a), 11'(b), 11'(c), 11'(d), 11'(e)});
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, center, dead zone edges, snap on both axes
    queue_frame(0, 2047, 1024, 1024, 0);
    queue_frame(1024, 1024, 2047, 0, 2047);
    queue_frame(1044, 1004, 1300, 1030, 1);
    queue_frame(1025, 1023, 1030, 1300, 1100);
    queue_frame(1010, 1040, 700, 1020, 1684);
    queue_frame(364, 1684, 1040, 1500, 1024);
    queue_frame(1036, 1012, 1700, 1700, 1043);
    queue_frame(1012, 1036, 1060, 500, 1005);
    drain();
    reg_write(sdz_pkg::RegCenter, 0);
    reg_write(sdz_pkg::RegSpan, 0);
    reg_write(sdz_pkg::RegDeadZone, 0);
    reg_write(sdz_pkg::RegMainMin, 0);
    reg_write(sdz_pkg::RegCrossAbs, 32'h7FFF);
    reg_write(sdz_pkg::RegCrossRat, 32'h7FFF);
    queue_frame(0, 2047, 1, 0, 5);
    queue_frame(2047, 0, 0, 2047, 1);
    queue_random(40);
    drain();
    reg_write(sdz_pkg::RegCenter, 2047);
    reg_write(sdz_pkg::RegSpan, 1);
    reg_write(sdz_pkg::RegDeadZone, 16384);
    queue_frame(2047, 0, 2046, 0, 1000);
    queue_random(40);
    drain();
    reg_write(sdz_pkg::RegCenter, 1024);
    reg_write(sdz_pkg::RegSpan, 2047);
    reg_write(sdz_pkg::RegDeadZone, 30);
    reg_write(sdz_pkg::RegMainMin, 16384);
    reg_write(sdz_pkg::RegCrossAbs, 0);
    reg_write(sdz_pkg::RegCrossRat, 0);
    queue_random(60);
    drain();
    reg_write(sdz_pkg::RegSpan, 300);
    reg_write(sdz_pkg::RegDeadZone, 32'hFFFF_FFFF);
    queue_random(20);
    drain();
    reg_write(sdz_pkg::RegSpan, 660);
    reg_write(sdz_pkg::RegDeadZone, 200);
    reg_write(sdz_pkg::RegMainMin, 1000);
    reg_write(sdz_pkg::RegCrossAbs, 16384);
    reg_write(sdz_pkg::RegCrossRat, 16384);
    queue_random(120);
    drain();
    reg_write(sdz_pkg::RegCenter, $urandom_range(900, 1150));
    reg_write(sdz_pkg::RegSpan, $urandom_range(200, 900));
    reg_write(sdz_pkg::RegDeadZone, 492);
    reg_write(sdz_pkg::RegMainMin, 2458);
    reg_write(sdz_pkg::RegCrossAbs, 1311);
    reg_write(sdz_pkg::RegCrossRat, 5734);
    queue_random(120);
    drain();
    $display("covered %0d frames, %0d results checked over seven register settings",
             frames_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
